// ----- rtl/core/pmas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmas_pkg
// Shared constants, types and helpers for the point-mass aircraft step core
// ----------------------------------------------------------------------------
package pmas_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W        = 5;

  localparam logic [2:0] REG_GRAVITY     = 3'd0;
  localparam logic [2:0] REG_AIR_DENSITY = 3'd1;
  localparam logic [2:0] REG_MASS        = 3'd2;
  localparam logic [2:0] REG_WING_AREA   = 3'd3;
  localparam logic [2:0] REG_LIFT_COEF   = 3'd4;
  localparam logic [2:0] REG_DRAG_COEF   = 3'd5;
  localparam logic [2:0] REG_MAX_THRUST  = 3'd6;
  localparam logic [2:0] REG_MAX_ROLL    = 3'd7;

  localparam logic [31:0] RST_GRAVITY     = 32'd642646;
  localparam logic [31:0] RST_AIR_DENSITY = 32'd80282;
  localparam logic [31:0] RST_MASS        = 32'd327680;
  localparam logic [31:0] RST_WING_AREA   = 32'd19661;
  localparam logic [31:0] RST_LIFT_COEF   = 32'd32768;
  localparam logic [31:0] RST_DRAG_COEF   = 32'd3277;
  localparam logic [31:0] RST_MAX_THRUST  = 32'd655360;
  localparam logic [31:0] RST_MAX_ROLL    = 32'd22938;

  localparam int CORDIC_BITS  = 30;
  localparam int CORDIC_ITERS = 28;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef logic signed [65:0] wide_t;

  localparam wide_t W32_MAX = wide_t'(64'd2147483647);
  localparam wide_t W32_MIN = -wide_t'(64'd2147483648);
  localparam wide_t W48_MAX = wide_t'(64'd140737488355327);
  localparam wide_t W48_MIN = -wide_t'(64'd140737488355328);

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > W32_MAX) begin
      sat32 = 32'sh7fffffff;
    end else if (v < W32_MIN) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input wide_t v);
    if (v > W48_MAX) begin
      sat48 = 48'sh7fffffffffff;
    end else if (v < W48_MIN) begin
      sat48 = 48'sh800000000000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  function automatic logic signed [32:0] u33(input logic [31:0] v);
    u33 = $signed({1'b0, v});
  endfunction

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    atan_q30 = 35'sd843314857;
      5'd1:    atan_q30 = 35'sd497837829;
      5'd2:    atan_q30 = 35'sd263043837;
      5'd3:    atan_q30 = 35'sd133525159;
      5'd4:    atan_q30 = 35'sd67021687;
      5'd5:    atan_q30 = 35'sd33543516;
      5'd6:    atan_q30 = 35'sd16775851;
      5'd7:    atan_q30 = 35'sd8388437;
      5'd8:    atan_q30 = 35'sd4194283;
      5'd9:    atan_q30 = 35'sd2097149;
      5'd10:   atan_q30 = 35'sd1048576;
      default: atan_q30 = $signed(35'd1 << (5'd30 - i));
    endcase
  endfunction

endpackage

// ----- rtl/core/pmas_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmas_cmd_if / pmas_res_if
// Valid/ready channels for command words and state result words
// ----------------------------------------------------------------------------
interface pmas_cmd_if;
  logic               valid;
  logic               ready;
  logic        [31:0] time_step;
  logic signed [31:0] roll_command;
  logic signed [31:0] pitch_command;
  logic signed [31:0] throttle_command;

  modport source (output valid, time_step, roll_command, pitch_command, throttle_command,
                  input ready);
  modport sink (input valid, time_step, roll_command, pitch_command, throttle_command,
                output ready);
endinterface

interface pmas_res_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [31:0] flight_path_angle;
  logic signed [31:0] heading_angle;
  logic signed [31:0] bank_angle;
  logic signed [31:0] air_speed;

  modport source (output valid, pos_x, pos_y, pos_z, flight_path_angle, heading_angle,
                  bank_angle, air_speed, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, flight_path_angle, heading_angle,
                bank_angle, air_speed, output ready);
endinterface

// ----- rtl/core/point_mass_aircraft_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_mass_aircraft_step
// Fixed-point point-mass aircraft, one Euler step per command word
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// cmd      in   valid/ready    time_step, roll/pitch/throttle commands
// res      out  valid/ready    pos_x/y/z, path, heading, bank, airspeed
// apb      in   psel/penable   eight 32-bit coefficient registers
//
// each word uses the bit-serial divider up to three times, the cordic
// engine three times and the multiplier for the remaining products
// cmd.ready is high only while idle; a finished word waits in the output
// register, so the next command is taken while res is stalled
// synchronous reset clears the model state and loads the register defaults
// ----------------------------------------------------------------------------
module point_mass_aircraft_step #(
  parameter int FRAC_BITS = pmas_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  pmas_cmd_if.sink                    cmd,
  pmas_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pmas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pmas_pkg::*;

  localparam int QW        = 32 + FRAC_BITS;
  localparam int CNT_W     = $clog2(QW + 1);
  localparam int RW        = 62 - FRAC_BITS;
  localparam int RED_STEPS = 29 - FRAC_BITS;
  localparam int SH        = CORDIC_BITS - FRAC_BITS;
  localparam logic [RW-1:0] TWO_PI_TOP = RW'(TWO_PI_Q30) << (RED_STEPS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ISSUE = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_MWB   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_DWB   = 4'd5;
  localparam logic [3:0] ST_RED   = 4'd6;
  localparam logic [3:0] ST_FOLD  = 4'd7;
  localparam logic [3:0] ST_ROT   = 4'd8;
  localparam logic [3:0] ST_CWB   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  localparam logic [5:0] P_LIM    = 6'd0;
  localparam logic [5:0] P_CLAMP  = 6'd1;
  localparam logic [5:0] P_THRUST = 6'd2;
  localparam logic [5:0] P_CC1    = 6'd3;
  localparam logic [5:0] P_VV     = 6'd4;
  localparam logic [5:0] P_CC2    = 6'd5;
  localparam logic [5:0] P_LIFT   = 6'd6;
  localparam logic [5:0] P_DRAG   = 6'd7;
  localparam logic [5:0] P_WEIGHT = 6'd8;
  localparam logic [5:0] P_PITCH  = 6'd9;
  localparam logic [5:0] P_SG     = 6'd10;
  localparam logic [5:0] P_SPSI   = 6'd11;
  localparam logic [5:0] P_SPHI   = 6'd12;
  localparam logic [5:0] P_VCG    = 6'd13;
  localparam logic [5:0] P_DX     = 6'd14;
  localparam logic [5:0] P_DY     = 6'd15;
  localparam logic [5:0] P_DZ     = 6'd16;
  localparam logic [5:0] P_GS     = 6'd17;
  localparam logic [5:0] P_TD     = 6'd18;
  localparam logic [5:0] P_DIV1   = 6'd19;
  localparam logic [5:0] P_DV     = 6'd20;
  localparam logic [5:0] P_MV     = 6'd21;
  localparam logic [5:0] P_MVC    = 6'd22;
  localparam logic [5:0] P_NUM1   = 6'd23;
  localparam logic [5:0] P_DIV2   = 6'd24;
  localparam logic [5:0] P_NUM2   = 6'd25;
  localparam logic [5:0] P_DIV3   = 6'd26;
  localparam logic [5:0] P_PX     = 6'd27;
  localparam logic [5:0] P_PY     = 6'd28;
  localparam logic [5:0] P_PZ     = 6'd29;
  localparam logic [5:0] P_SPD    = 6'd30;
  localparam logic [5:0] P_GAM    = 6'd31;
  localparam logic [5:0] P_HDG    = 6'd32;

  localparam logic [1:0] K_ALU = 2'd0;
  localparam logic [1:0] K_MUL = 2'd1;
  localparam logic [1:0] K_DIV = 2'd2;
  localparam logic [1:0] K_COR = 2'd3;

  logic [3:0] state;
  logic [5:0] pc;
  logic [CNT_W-1:0] cnt;

  logic [31:0] gravity, air_density, vehicle_mass, wing_area;
  logic [31:0] lift_coefficient, drag_coefficient, max_thrust, max_roll_rate;

  logic signed [47:0] position_x, position_y, position_z;
  logic signed [31:0] path_angle, heading, bank, speed;

  logic        [31:0] dt;
  logic signed [31:0] droll, dpitch, thr;
  logic signed [31:0] rlim, plim, thrust, cc, vv, lift, drag, weight, surplus;
  logic signed [31:0] sg, cg, spsi, cpsi, sphi, cphi;
  logic signed [31:0] vcg, dx, dy, dz, gs, tmd, q1, dv, mv, mvc, num, dgamma, dpsi;

  // multiplier
  logic        [31:0] ma, mb;
  logic               msign;
  logic        [63:0] prod;
  logic        [63:0] pshift;
  wide_t              pmag, pval;
  logic signed [31:0] psat;

  // divider
  logic        [QW-1:0] rq;
  logic        [31:0]   rem, den;
  logic                 dsign, dzero, nneg, nzero;
  logic        [32:0]   rem_sh;
  logic                 ge;
  wide_t                qval;
  logic signed [31:0]   qres;

  // cordic
  logic        [RW-1:0] rm, tp, r0, r0mag;
  logic                 rneg, flip;
  logic signed [34:0]   cr, rs, r1, r2;
  logic                 flip_n;
  logic signed [33:0]   cx, cy, dxs, dys, cxs, cys;
  logic signed [31:0]   cosv, sinv;
  logic signed [34:0]   at;

  // operand selection
  logic        [1:0]  kind;
  logic signed [32:0] a_op, b_op, a_mag, b_mag, dden, dmag, nmag;
  logic signed [31:0] dnum, ang;

  // step arithmetic
  logic signed [32:0] rl33, pl33, droll_c, dpitch_c, thr33, one33, lw;
  logic signed [31:0] diff_max;

  logic               out_valid;
  logic signed [47:0] o_pos_x, o_pos_y, o_pos_z;
  logic signed [31:0] o_path, o_heading, o_bank, o_speed;

  always_comb begin
    kind = K_ALU;
    a_op = '0;
    b_op = '0;
    dnum = '0;
    dden = '0;
    ang  = '0;
    case (pc)
      P_LIM:    begin kind = K_MUL; a_op = u33(dt); b_op = u33(max_roll_rate); end
      P_THRUST: begin kind = K_MUL; a_op = 33'(thr); b_op = u33(max_thrust); end
      P_CC1:    begin kind = K_MUL; a_op = u33(wing_area); b_op = u33(air_density); end
      P_VV:     begin kind = K_MUL; a_op = 33'(speed); b_op = 33'(speed); end
      P_CC2:    begin kind = K_MUL; a_op = 33'(cc); b_op = 33'(vv); end
      P_LIFT:   begin kind = K_MUL; a_op = u33(lift_coefficient); b_op = 33'(cc); end
      P_DRAG:   begin kind = K_MUL; a_op = u33(drag_coefficient); b_op = 33'(cc); end
      P_WEIGHT: begin kind = K_MUL; a_op = u33(vehicle_mass); b_op = u33(gravity); end
      P_SG:     begin kind = K_COR; ang = path_angle; end
      P_SPSI:   begin kind = K_COR; ang = heading; end
      P_SPHI:   begin kind = K_COR; ang = bank; end
      P_VCG:    begin kind = K_MUL; a_op = 33'(speed); b_op = 33'(cg); end
      P_DX:     begin kind = K_MUL; a_op = 33'(vcg); b_op = 33'(cpsi); end
      P_DY:     begin kind = K_MUL; a_op = 33'(vcg); b_op = 33'(spsi); end
      P_DZ:     begin kind = K_MUL; a_op = 33'(speed); b_op = 33'(sg); end
      P_GS:     begin kind = K_MUL; a_op = u33(gravity); b_op = 33'(sg); end
      P_DIV1:   begin kind = K_DIV; dnum = tmd; dden = u33(vehicle_mass); end
      P_MV:     begin kind = K_MUL; a_op = u33(vehicle_mass); b_op = 33'(speed); end
      P_MVC:    begin kind = K_MUL; a_op = 33'(mv); b_op = 33'(cg); end
      P_NUM1:   begin kind = K_MUL; a_op = 33'(surplus); b_op = 33'(cphi); end
      P_DIV2:   begin kind = K_DIV; dnum = num; dden = 33'(mv); end
      P_NUM2:   begin kind = K_MUL; a_op = 33'(lift); b_op = 33'(sphi); end
      P_DIV3:   begin kind = K_DIV; dnum = num; dden = 33'(mvc); end
      P_PX:     begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dx); end
      P_PY:     begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dy); end
      P_PZ:     begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dz); end
      P_SPD:    begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dv); end
      P_GAM:    begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dgamma); end
      P_HDG:    begin kind = K_MUL; a_op = u33(dt); b_op = 33'(dpsi); end
      default:  kind = K_ALU;
    endcase
  end

  assign a_mag = a_op[32] ? -a_op : a_op;
  assign b_mag = b_op[32] ? -b_op : b_op;
  assign nmag  = dnum[31] ? -33'(dnum) : 33'(dnum);
  assign dmag  = dden[32] ? -dden : dden;

  assign pshift = prod >> FRAC_BITS;
  assign pmag   = wide_t'({2'b00, pshift});
  assign pval   = msign ? -pmag : pmag;
  assign psat   = sat32(pval);

  assign rem_sh = {rem, rq[QW-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign qval   = dsign ? -wide_t'({{(66-QW){1'b0}}, rq}) : wide_t'({{(66-QW){1'b0}}, rq});
  assign qres   = !dzero ? sat32(qval) :
                  nzero  ? 32'sd0 :
                  nneg   ? 32'sh80000000 : 32'sh7fffffff;

  assign r0    = {ang, {SH{1'b0}}};
  assign r0mag = ang[31] ? -r0 : r0;
  assign rs    = rneg ? -$signed(rm[34:0]) : $signed(rm[34:0]);
  assign r1    = (rs > PI_Q30) ? rs - TWO_PI_Q30 : (rs < -PI_Q30) ? rs + TWO_PI_Q30 : rs;

  always_comb begin
    r2     = r1;
    flip_n = 1'b0;
    if (r1 > HALF_PI_Q30) begin
      r2     = PI_Q30 - r1;
      flip_n = 1'b1;
    end else if (r1 < -HALF_PI_Q30) begin
      r2     = -PI_Q30 - r1;
      flip_n = 1'b1;
    end
  end

  assign dxs  = cy >>> cnt[4:0];
  assign dys  = cx >>> cnt[4:0];
  assign at   = atan_q30(cnt[4:0]);
  assign cxs  = cx >>> SH;
  assign cys  = cy >>> SH;
  assign cosv = flip ? -cxs[31:0] : cxs[31:0];
  assign sinv = cys[31:0];

  assign rl33     = 33'(rlim);
  assign pl33     = 33'(plim);
  assign droll_c  = (33'(droll) > rl33) ? rl33 : (33'(droll) < -rl33) ? -rl33 : 33'(droll);
  assign dpitch_c = (33'(dpitch) > pl33) ? pl33 :
                    (33'(dpitch) < -pl33) ? -pl33 : 33'(dpitch);
  assign one33    = 33'sd1 <<< FRAC_BITS;
  assign thr33    = (33'(thr) > one33) ? one33 : (thr < 0) ? 33'sd0 : 33'(thr);
  assign lw       = 33'(lift) - 33'(weight);
  assign diff_max = (lw > 0) ? lw[31:0] : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pc               <= P_LIM;
      cnt              <= '0;
      out_valid        <= 1'b0;
      gravity          <= RST_GRAVITY;
      air_density      <= RST_AIR_DENSITY;
      vehicle_mass     <= RST_MASS;
      wing_area        <= RST_WING_AREA;
      lift_coefficient <= RST_LIFT_COEF;
      drag_coefficient <= RST_DRAG_COEF;
      max_thrust       <= RST_MAX_THRUST;
      max_roll_rate    <= RST_MAX_ROLL;
      position_x       <= '0;
      position_y       <= '0;
      position_z       <= '0;
      path_angle       <= '0;
      heading          <= '0;
      bank             <= '0;
      speed            <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_GRAVITY:     gravity          <= pwdata;
          REG_AIR_DENSITY: air_density      <= pwdata;
          REG_MASS:        vehicle_mass     <= pwdata;
          REG_WING_AREA:   wing_area        <= pwdata;
          REG_LIFT_COEF:   lift_coefficient <= pwdata;
          REG_DRAG_COEF:   drag_coefficient <= pwdata;
          REG_MAX_THRUST:  max_thrust       <= pwdata;
          REG_MAX_ROLL:    max_roll_rate    <= pwdata;
          default:         max_roll_rate    <= max_roll_rate;
        endcase
      end

      if (out_valid && res.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            dt     <= cmd.time_step;
            droll  <= cmd.roll_command;
            dpitch <= cmd.pitch_command;
            thr    <= cmd.throttle_command;
            pc     <= P_LIM;
            state  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          case (kind)
            K_MUL: begin
              ma    <= a_mag[31:0];
              mb    <= b_mag[31:0];
              msign <= a_op[32] ^ b_op[32];
              state <= ST_MUL;
            end
            K_DIV: begin
              rq    <= {nmag[31:0], {FRAC_BITS{1'b0}}};
              den   <= dmag[31:0];
              rem   <= '0;
              dsign <= dnum[31] ^ dden[32];
              dzero <= (dden == 0);
              nneg  <= dnum[31];
              nzero <= (dnum == 0);
              cnt   <= '0;
              state <= ST_DIV;
            end
            K_COR: begin
              rm    <= r0mag;
              rneg  <= ang[31];
              tp    <= TWO_PI_TOP;
              cnt   <= '0;
              state <= ST_RED;
            end
            default: begin
              case (pc)
                P_CLAMP: begin
                  bank   <= sat32(wide_t'(bank) + wide_t'(droll_c));
                  dpitch <= dpitch_c[31:0];
                  thr    <= thr33[31:0];
                  pc     <= pc + 6'd1;
                end
                P_PITCH: begin
                  if (lw > 0 || dpitch > 0) begin
                    path_angle <= sat32(wide_t'(path_angle) + wide_t'(dpitch));
                  end
                  surplus <= diff_max;
                  pc      <= pc + 6'd1;
                end
                P_TD: begin
                  tmd <= sat32(wide_t'(thrust) - wide_t'(drag));
                  pc  <= pc + 6'd1;
                end
                P_DV: begin
                  dv <= sat32(wide_t'(q1) + wide_t'(gs));
                  if (speed > 0) begin
                    pc <= P_MV;
                  end else begin
                    dgamma <= '0;
                    dpsi   <= '0;
                    pc     <= P_PX;
                  end
                end
                default: pc <= pc + 6'd1;
              endcase
            end
          endcase
        end
        ST_MUL: begin
          prod  <= ma * mb;
          state <= ST_MWB;
        end
        ST_MWB: begin
          pc    <= pc + 6'd1;
          state <= (pc == P_HDG) ? ST_DONE : ST_ISSUE;
          case (pc)
            P_LIM:    begin rlim <= psat; plim <= sat32(pval >>> 2); end
            P_THRUST: thrust <= psat;
            P_CC1:    cc <= psat;
            P_VV:     vv <= psat;
            P_CC2:    cc <= psat >>> 1;
            P_LIFT:   lift <= psat;
            P_DRAG:   drag <= psat;
            P_WEIGHT: weight <= psat;
            P_VCG:    vcg <= psat;
            P_DX:     dx <= psat;
            P_DY:     dy <= psat;
            P_DZ:     dz <= sat32(-pval);
            P_GS:     gs <= psat;
            P_MV:     mv <= psat;
            P_MVC:    mvc <= psat;
            P_NUM1:   num <= psat;
            P_NUM2:   num <= psat;
            P_PX:     position_x <= sat48(wide_t'(position_x) + pval);
            P_PY:     position_y <= sat48(wide_t'(position_y) + pval);
            P_PZ:     position_z <= sat48(wide_t'(position_z) + pval);
            P_SPD:    speed <= sat32(wide_t'(speed) + pval);
            P_GAM:    path_angle <= sat32(wide_t'(path_angle) + pval);
            P_HDG:    heading <= sat32(wide_t'(heading) + pval);
            default:  rlim <= rlim;
          endcase
        end
        ST_DIV: begin
          rem <= ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
          rq  <= {rq[QW-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QW - 1)) begin
            state <= ST_DWB;
          end
        end
        ST_DWB: begin
          pc    <= pc + 6'd1;
          state <= ST_ISSUE;
          case (pc)
            P_DIV1:  q1 <= qres;
            P_DIV2:  dgamma <= sat32(-wide_t'(qres));
            P_DIV3:  dpsi <= sat32(-wide_t'(qres));
            default: q1 <= q1;
          endcase
        end
        ST_RED: begin
          if (rm >= tp) begin
            rm <= rm - tp;
          end
          tp  <= tp >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(RED_STEPS - 1)) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          cr    <= r2;
          flip  <= flip_n;
          cx    <= GAIN_Q30;
          cy    <= '0;
          cnt   <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (cr >= 0) begin
            cx <= cx - dxs;
            cy <= cy + dys;
            cr <= cr - at;
          end else begin
            cx <= cx + dxs;
            cy <= cy - dys;
            cr <= cr + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_ITERS - 1)) begin
            state <= ST_CWB;
          end
        end
        ST_CWB: begin
          pc    <= pc + 6'd1;
          state <= ST_ISSUE;
          case (pc)
            P_SG:    begin sg <= sinv; cg <= cosv; end
            P_SPSI:  begin spsi <= sinv; cpsi <= cosv; end
            P_SPHI:  begin sphi <= sinv; cphi <= cosv; end
            default: sg <= sg;
          endcase
        end
        ST_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            o_pos_x   <= position_x;
            o_pos_y   <= position_y;
            o_pos_z   <= position_z;
            o_path    <= path_angle;
            o_heading <= heading;
            o_bank    <= bank;
            o_speed   <= speed;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cmd.ready             = (state == ST_IDLE);
  assign res.valid             = out_valid;
  assign res.pos_x             = o_pos_x;
  assign res.pos_y             = o_pos_y;
  assign res.pos_z             = o_pos_z;
  assign res.flight_path_angle = o_path;
  assign res.heading_angle     = o_heading;
  assign res.bank_angle        = o_bank;
  assign res.air_speed         = o_speed;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_GRAVITY:     prdata = gravity;
      REG_AIR_DENSITY: prdata = air_density;
      REG_MASS:        prdata = vehicle_mass;
      REG_WING_AREA:   prdata = wing_area;
      REG_LIFT_COEF:   prdata = lift_coefficient;
      REG_DRAG_COEF:   prdata = drag_coefficient;
      REG_MAX_THRUST:  prdata = max_thrust;
      REG_MAX_ROLL:    prdata = max_roll_rate;
      default:         prdata = '0;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> state == ST_ISSUE && pc == P_LIM)
    else $error("accepted word did not start the step sequence");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt < CNT_W'(QW))
    else $error("divider ran past its last bit");

  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROT |-> cnt < CNT_W'(CORDIC_ITERS))
    else $error("cordic ran past its last iteration");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && (!out_valid || res.ready) |=> out_valid && state == ST_IDLE)
    else $error("finished word not moved to the output register");

endmodule
